>>> hdl/cbal_pkg.sv
// ----------------------------------------------------------------------------
// cbal_pkg
// Shared constants, types and the Bernstein weight table of the arc length
// pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package cbal_pkg;

    localparam int STEPS         = 99;
    localparam int FRACTION_BITS = 16;

    localparam int CRD_IN_W = 32;
    localparam int PT_W     = CRD_IN_W + 2;
    localparam int W_W      = FRACTION_BITS + 1;
    localparam int PRD_W    = W_W + 1 + PT_W;
    localparam int SUM_W    = PRD_W + 2;
    localparam int CRD_W    = SUM_W - FRACTION_BITS;
    localparam int DIF_W    = CRD_W + 1;
    localparam int MAG_W    = DIF_W - 1;
    localparam int LO_W     = MAG_W / 2;
    localparam int HI_W     = MAG_W - LO_W;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int RAD_W    = SQ_W + 2;
    localparam int ROOT_W   = RAD_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQ_PER   = 7;
    localparam int SQ_STG   = (ROOT_W + SQ_PER - 1) / SQ_PER;
    localparam int LEN_W    = 48;
    localparam int M_W      = $clog2(STEPS + 1);
    localparam int PADDR_W  = 3;

    localparam logic [PADDR_W-1:0] REG_BEZIER_MODE = PADDR_W'(0);

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_tok;

    typedef logic [3:0][W_W-1:0] t_wrow;
    typedef t_wrow [STEPS:0]     t_wtab;

    function automatic t_wtab build_wtab();
        t_wtab          tab;
        longint unsigned one;
        longint unsigned half;
        longint unsigned t;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t2;
        one  = longint'(1) << FRACTION_BITS;
        half = longint'(1) << (FRACTION_BITS - 1);
        for (int m = 0; m <= STEPS; m++) begin
            t = (longint'(m) * one + longint'(STEPS / 2)) / STEPS;
            if (t > one) begin
                t = one;
            end
            u  = one - t;
            u2 = (u * u + half) >> FRACTION_BITS;
            t2 = (t * t + half) >> FRACTION_BITS;
            tab[m][0] = W_W'((u2 * u + half) >> FRACTION_BITS);
            tab[m][1] = W_W'((3 * u2 * t + half) >> FRACTION_BITS);
            tab[m][2] = W_W'((3 * u * t2 + half) >> FRACTION_BITS);
            tab[m][3] = W_W'((t2 * t + half) >> FRACTION_BITS);
        end
        return tab;
    endfunction

    localparam t_wtab WTAB = build_wtab();

endpackage

`default_nettype wire

>>> hdl/cbal_in_if.sv
// ----------------------------------------------------------------------------
// cbal_in_if / cbal_out_if
// Valid/ready channels carrying one curve piece and one length.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbal_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
    logic signed [31:0] start_handle_x;
    logic signed [31:0] start_handle_y;
    logic signed [31:0] start_handle_z;
    logic signed [31:0] end_x;
    logic signed [31:0] end_y;
    logic signed [31:0] end_z;
    logic signed [31:0] end_handle_x;
    logic signed [31:0] end_handle_y;
    logic signed [31:0] end_handle_z;

    modport source (output valid, start_x, start_y, start_z, start_handle_x,
                    start_handle_y, start_handle_z, end_x, end_y, end_z,
                    end_handle_x, end_handle_y, end_handle_z, input ready);
    modport sink (input valid, start_x, start_y, start_z, start_handle_x,
                  start_handle_y, start_handle_z, end_x, end_y, end_z,
                  end_handle_x, end_handle_y, end_handle_z, output ready);
endinterface

interface cbal_out_if;
    logic        valid;
    logic        ready;
    logic [47:0] piece_length;

    modport source (output valid, piece_length, input ready);
    modport sink (input valid, piece_length, output ready);
endinterface

`default_nettype wire

>>> hdl/cubic_bezier_arc_length.sv
// ----------------------------------------------------------------------------
// cubic_bezier_arc_length
// Arc length of one cubic Bezier piece by summing chord lengths.
// ----------------------------------------------------------------------------
// The input channel takes one curve piece per transaction; the output channel
// returns one unsigned Q48.0 length per piece, in order. A sequencer walks the
// sample table, issuing one sample per cycle unless stalled, into weighted
// sums, chord differences, split squaring and a six-stage square root. A
// Bezier piece issues all STEPS + 1 samples, a straight one only its end
// points. The next piece is accepted in the cycle its predecessor issues its
// last sample, so pieces follow without a gap. A length passes the product,
// sum, chord, difference, magnitude, partial product, square, radicand, root
// and output registers. When the receiver stalls with a result waiting, the
// whole pipeline holds. The APB register bezier_mode sits at address 0, resets
// to 1, and is sampled when a piece is accepted. Reset empties the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_arc_length
    import cbal_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    cbal_in_if.sink                 i_in,
    cbal_out_if.source              o_out,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic r_mode;
    logic en;
    logic issue;
    logic accept;
    logic seq_last;

    logic             r_busy;
    logic [M_W-1:0]   r_m;
    logic             r_item_mode;
    logic signed [PT_W-1:0] r_p [4][3];

    t_tok r_t1, r_t2, r_t3, r_t4, r_t5, r_t6, r_t7, r_t8;
    t_tok n_t1;
    t_tok sq_tok;
    logic [ROOT_W-1:0] sq_root;

    logic signed [PRD_W-1:0] r_prd [3][4];
    logic signed [PRD_W-1:0] n_prd [3][4];
    logic signed [SUM_W-1:0] r_sum [3];
    logic signed [CRD_W-1:0] r_crd [3];
    logic signed [CRD_W-1:0] n_crd [3];
    logic signed [CRD_W-1:0] r_prev [3];
    logic signed [DIF_W-1:0] r_dif [3];
    logic [MAG_W-1:0]        r_mag [3];
    logic [2*HI_W-1:0]       r_hh [3];
    logic [HI_W+LO_W-1:0]    r_hl [3];
    logic [2*LO_W-1:0]       r_ll [3];
    logic [SQ_W-1:0]         r_sq [3];
    logic [RAD_W-1:0]        r_rad;

    logic [LEN_W-1:0] r_acc;
    logic [LEN_W:0]   n_tot;
    logic [LEN_W-1:0] n_len;
    logic             r_out_valid;
    logic [LEN_W-1:0] r_len;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BEZIER_MODE) ? {31'd0, r_mode} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b1;
        end else if (psel && penable && pwrite && pready
                     && paddr == REG_BEZIER_MODE) begin
            r_mode <= pwdata[0];
        end
    end

    assign en       = !r_out_valid || o_out.ready;
    assign seq_last = (r_m == M_W'(STEPS));
    assign issue    = en && r_busy;
    assign accept   = i_in.valid && i_in.ready;
    assign i_in.ready = en && (!r_busy || seq_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_m    <= '0;
        end else if (accept) begin
            r_busy <= 1'b1;
            r_m    <= '0;
        end else if (issue) begin
            if (seq_last) begin
                r_busy <= 1'b0;
            end
            r_m <= (r_item_mode && !seq_last) ? r_m + M_W'(1) : M_W'(STEPS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item_mode <= r_mode;
            r_p[0][0] <= PT_W'(i_in.start_x);
            r_p[0][1] <= PT_W'(i_in.start_y);
            r_p[0][2] <= PT_W'(i_in.start_z);
            r_p[1][0] <= PT_W'(i_in.start_handle_x);
            r_p[1][1] <= PT_W'(i_in.start_handle_y);
            r_p[1][2] <= PT_W'(i_in.start_handle_z);
            r_p[3][0] <= PT_W'(i_in.end_x);
            r_p[3][1] <= PT_W'(i_in.end_y);
            r_p[3][2] <= PT_W'(i_in.end_z);
            r_p[2][0] <= (PT_W'(i_in.end_x) <<< 1) - PT_W'(i_in.end_handle_x);
            r_p[2][1] <= (PT_W'(i_in.end_y) <<< 1) - PT_W'(i_in.end_handle_y);
            r_p[2][2] <= (PT_W'(i_in.end_z) <<< 1) - PT_W'(i_in.end_handle_z);
        end
    end

    always_comb begin
        n_t1.valid = r_busy;
        n_t1.first = (r_m == '0);
        n_t1.last  = seq_last;
        for (int k = 0; k < 3; k++) begin
            for (int i = 0; i < 4; i++) begin
                n_prd[k][i] = $signed({1'b0, WTAB[r_m][i]}) * r_p[i][k];
            end
        end
        for (int k = 0; k < 3; k++) begin
            logic [SUM_W-1:0] a;
            logic [SUM_W-1:0] q;
            a = r_sum[k][SUM_W-1] ? SUM_W'(-r_sum[k]) : SUM_W'(r_sum[k]);
            q = (a + SUM_W'(1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
            n_crd[k] = r_sum[k][SUM_W-1] ? -CRD_W'(q) : CRD_W'(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0; r_t2 <= '0; r_t3 <= '0; r_t4 <= '0;
            r_t5 <= '0; r_t6 <= '0; r_t7 <= '0; r_t8 <= '0;
        end else if (en) begin
            r_t1 <= n_t1; r_t2 <= r_t1; r_t3 <= r_t2; r_t4 <= r_t3;
            r_t5 <= r_t4; r_t6 <= r_t5; r_t7 <= r_t6; r_t8 <= r_t7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 4; i++) begin
                    r_prd[k][i] <= n_prd[k][i];
                end
                r_sum[k] <= SUM_W'(r_prd[k][0]) + SUM_W'(r_prd[k][1])
                          + SUM_W'(r_prd[k][2]) + SUM_W'(r_prd[k][3]);
                r_crd[k] <= n_crd[k];
                if (r_t3.valid) begin
                    r_prev[k] <= r_crd[k];
                end
                r_dif[k] <= DIF_W'(r_crd[k]) - DIF_W'(r_prev[k]);
                r_mag[k] <= r_dif[k][DIF_W-1] ? MAG_W'(-r_dif[k]) : MAG_W'(r_dif[k]);
                r_hh[k]  <= r_mag[k][MAG_W-1:LO_W] * r_mag[k][MAG_W-1:LO_W];
                r_hl[k]  <= r_mag[k][MAG_W-1:LO_W] * r_mag[k][LO_W-1:0];
                r_ll[k]  <= r_mag[k][LO_W-1:0] * r_mag[k][LO_W-1:0];
                r_sq[k]  <= (SQ_W'(r_hh[k]) << (2 * LO_W))
                          + (SQ_W'(r_hl[k]) << (LO_W + 1)) + SQ_W'(r_ll[k]);
            end
            r_rad <= RAD_W'(r_sq[0]) + RAD_W'(r_sq[1]) + RAD_W'(r_sq[2]);
        end
    end

    cbal_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tok   (r_t8),
        .i_rad   (r_rad),
        .o_tok   (sq_tok),
        .o_root  (sq_root)
    );

    always_comb begin
        n_tot = (LEN_W + 1)'(r_acc) + (LEN_W + 1)'(sq_root);
        n_len = n_tot[LEN_W] ? {LEN_W{1'b1}} : n_tot[LEN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (en && sq_tok.valid) begin
            r_acc <= sq_tok.first ? '0 : n_len;
        end
        if (en && sq_tok.valid && sq_tok.last) begin
            r_len <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= sq_tok.valid && sq_tok.last;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.piece_length = r_len;

endmodule

`default_nettype wire

>>> hdl/cbal_sqrt.sv
// ----------------------------------------------------------------------------
// cbal_sqrt
// Pipelined integer square root, truncated, a few result bits per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cbal_sqrt
    import cbal_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_tok              i_tok,
    input  wire logic [RAD_W-1:0]  i_rad,
    output t_tok                   o_tok,
    output logic [ROOT_W-1:0]      o_root
);

    t_tok              r_tok  [SQ_STG];
    logic [RAD_W-1:0]  r_rad  [SQ_STG];
    logic [REM_W-1:0]  r_rem  [SQ_STG];
    logic [ROOT_W-1:0] r_root [SQ_STG];

    for (genvar s = 0; s < SQ_STG; s++) begin : g_stg
        logic [RAD_W-1:0]  p_rad;
        logic [REM_W-1:0]  p_rem;
        logic [ROOT_W-1:0] p_root;
        t_tok              in_tok;
        logic [RAD_W-1:0]  n_rad;
        logic [REM_W-1:0]  n_rem;
        logic [ROOT_W-1:0] n_root;
        logic [REM_W-1:0]  trial;

        if (s == 0) begin : g_head
            assign p_rad  = i_rad;
            assign p_rem  = '0;
            assign p_root = '0;
            assign in_tok = i_tok;
        end else begin : g_body
            assign p_rad  = r_rad[s-1];
            assign p_rem  = r_rem[s-1];
            assign p_root = r_root[s-1];
            assign in_tok = r_tok[s-1];
        end

        always_comb begin
            n_rad  = p_rad;
            n_rem  = p_rem;
            n_root = p_root;
            trial  = '0;
            for (int j = 0; j < SQ_PER; j++) begin
                if (s * SQ_PER + j < ROOT_W) begin
                    n_rem = {n_rem[REM_W-3:0], n_rad[RAD_W-1 -: 2]};
                    n_rad = {n_rad[RAD_W-3:0], 2'b00};
                    trial = REM_W'({n_root, 2'b01});
                    if (n_rem >= trial) begin
                        n_rem  = n_rem - trial;
                        n_root = {n_root[ROOT_W-2:0], 1'b1};
                    end else begin
                        n_root = {n_root[ROOT_W-2:0], 1'b0};
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_tok[s] <= '0;
            end else if (i_en) begin
                r_tok[s] <= in_tok;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rad[s]  <= n_rad;
                r_rem[s]  <= n_rem;
                r_root[s] <= n_root;
            end
        end
    end

    assign o_tok  = r_tok[SQ_STG-1];
    assign o_root = r_root[SQ_STG-1];

endmodule

`default_nettype wire

>>> hdl/cbal_chk.sv
// ----------------------------------------------------------------------------
// cbal_chk
// Port-level checks of the arc length block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cbal_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [47:0] i_len,
    input wire logic [31:0] i_prdata,
    input wire logic        i_pready
);

    a_hold_valid : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("Output transaction dropped while stalled.");

    a_hold_len : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_len))
        else $error("Output length changed while stalled.");

    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid right after reset.");

    a_regs : assert property (@(posedge i_clk)
        i_pready && i_prdata[31:1] == 31'd0)
        else $error("Register port read data or ready is wrong.");

endmodule

bind cubic_bezier_arc_length cbal_chk u_cbal_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_len       (o_out.piece_length),
    .i_prdata    (prdata),
    .i_pready    (pready)
);

`default_nettype wire

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Testbench of the cubic Bezier arc length block.
// Curve pieces are sent over the input channel, each length is predicted
// when its piece is accepted and compared in order with the block's output,
// in both modes and under several patterns of sender gaps and output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
    import cbal_pkg::*;
();

    localparam int RATE_ITEMS  = 1250;
    localparam int STALL_LIMIT = 6000;
    localparam int DRAIN_WAIT  = 40;

    typedef struct {
        logic signed [31:0] c [12];
    } t_piece;

    logic i_clk;
    logic i_rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    cbal_in_if  in_if ();
    cbal_out_if out_if ();

    cubic_bezier_arc_length dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    t_piece      pieces [$];
    logic [47:0] lengths [$];
    bit          mode_bezier;
    bit          took;
    int          idle_pct;
    int          stall_pct;
    int          errors;
    int          quiet_cycles;
    int          n_sent;
    int          n_checked;
    longint unsigned wgt [STEPS+1][4];

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic longint unsigned rnd_frac(longint unsigned x);
        return (x + (longint'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    endfunction

    function automatic void build_weights();
        longint unsigned one;
        longint unsigned t;
        longint unsigned u;
        longint unsigned u2;
        longint unsigned t2;
        one = longint'(1) << FRACTION_BITS;
        for (int m = 0; m <= STEPS; m++) begin
            t = (longint'(m) * one + longint'(STEPS / 2)) / STEPS;
            if (t > one) begin
                t = one;
            end
            u  = one - t;
            u2 = rnd_frac(u * u);
            t2 = rnd_frac(t * t);
            wgt[m][0] = rnd_frac(u2 * u);
            wgt[m][1] = rnd_frac(3 * u2 * t);
            wgt[m][2] = rnd_frac(3 * u * t2);
            wgt[m][3] = rnd_frac(t2 * t);
        end
    endfunction

    function automatic longint unsigned chord(longint dx, longint dy, longint dz);
        logic [127:0] ax;
        logic [127:0] ay;
        logic [127:0] az;
        logic [127:0] n;
        logic [127:0] r;
        logic [127:0] c;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        az = (dz < 0) ? -dz : dz;
        n = ax * ax + ay * ay + az * az;
        r = 0;
        for (int b = 40; b >= 0; b--) begin
            c = r | (128'd1 << b);
            if (c * c <= n) begin
                r = c;
            end
        end
        return r[63:0];
    endfunction

    function automatic void curve_point(int m, longint p [4][3], output longint q [3]);
        longint s;
        longint unsigned a;
        for (int k = 0; k < 3; k++) begin
            s = 0;
            for (int i = 0; i < 4; i++) begin
                s += longint'(wgt[m][i]) * p[i][k];
            end
            a = (s < 0) ? -s : s;
            a = rnd_frac(a);
            q[k] = (s < 0) ? -longint'(a) : longint'(a);
        end
    endfunction

    function automatic logic [47:0] arc_length(t_piece pc, bit bezier);
        longint p [4][3];
        longint prev [3];
        longint cur [3];
        longint unsigned total;
        for (int k = 0; k < 3; k++) begin
            p[0][k] = pc.c[k];
            p[1][k] = pc.c[3 + k];
            p[3][k] = pc.c[6 + k];
            p[2][k] = 2 * p[3][k] - longint'(pc.c[9 + k]);
        end
        total = 0;
        if (!bezier) begin
            total = chord(p[0][0] - p[3][0], p[0][1] - p[3][1], p[0][2] - p[3][2]);
        end else begin
            curve_point(0, p, prev);
            for (int m = 1; m <= STEPS; m++) begin
                curve_point(m, p, cur);
                total += chord(cur[0] - prev[0], cur[1] - prev[1], cur[2] - prev[2]);
                prev = cur;
            end
        end
        if (total > 64'hFFFF_FFFF_FFFF) begin
            total = 64'hFFFF_FFFF_FFFF;
        end
        return total[47:0];
    endfunction

    function automatic logic signed [31:0] rand_coord();
        case ($urandom_range(9))
            0: return 32'sh7FFF_FFFF;
            1: return 32'sh8000_0000;
            2, 3, 4: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_piece(logic signed [31:0] v [12]);
        t_piece pc;
        pc.c = v;
        pieces.push_back(pc);
    endtask

    task automatic add_random(int count);
        logic signed [31:0] v [12];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 12; i++) begin
                v[i] = rand_coord();
            end
            add_piece(v);
        end
    endtask

    task automatic add_directed();
        logic signed [31:0] v [12];
        for (int i = 0; i < 12; i++) v[i] = 0;
        add_piece(v);
        for (int i = 0; i < 12; i++) v[i] = 32'sh7FFF_FFFF;
        add_piece(v);
        for (int i = 0; i < 12; i++) v[i] = 32'sh8000_0000;
        add_piece(v);
        // Opposite corners with handles pushing the mirrored point out to 34 bits.
        for (int k = 0; k < 3; k++) begin
            v[k] = 32'sh8000_0000;
            v[3 + k] = 32'sh7FFF_FFFF;
            v[6 + k] = 32'sh7FFF_FFFF;
            v[9 + k] = 32'sh8000_0000;
        end
        add_piece(v);
        for (int k = 0; k < 3; k++) begin
            v[k] = 32'sh7FFF_FFFF;
            v[3 + k] = 32'sh8000_0000;
            v[6 + k] = 32'sh8000_0000;
            v[9 + k] = 32'sh7FFF_FFFF;
        end
        add_piece(v);
        // Straight line with handles on the nodes.
        for (int k = 0; k < 3; k++) begin
            v[k] = 0;
            v[3 + k] = 0;
            v[6 + k] = (k + 1) << 16;
            v[9 + k] = (k + 1) << 16;
        end
        add_piece(v);
        // Tiny curve, one LSB steps.
        for (int i = 0; i < 12; i++) v[i] = (i % 3 == 0) ? 1 : -1;
        add_piece(v);
        add_random(5);
    endtask

    task automatic reg_write(logic [PADDR_W-1:0] addr, logic [31:0] data);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        if (addr == REG_BEZIER_MODE) begin
            mode_bezier = data[0];
        end
    endtask

    task automatic drain();
        while (pieces.size() > 0 || in_if.valid || lengths.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            took <= 1'b0;
        end else begin
            took <= in_if.valid && in_if.ready;
            if (in_if.valid && in_if.ready) begin
                t_piece pc;
                pc.c = '{in_if.start_x, in_if.start_y, in_if.start_z,
                         in_if.start_handle_x, in_if.start_handle_y, in_if.start_handle_z,
                         in_if.end_x, in_if.end_y, in_if.end_z,
                         in_if.end_handle_x, in_if.end_handle_y, in_if.end_handle_z};
                lengths.push_back(arc_length(pc, mode_bezier));
                n_sent++;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid  <= 1'b0;
            out_if.ready <= 1'b0;
        end else begin
            if (!in_if.valid || took) begin
                if (pieces.size() > 0 && $urandom_range(99) >= idle_pct) begin
                    t_piece pc;
                    pc = pieces.pop_front();
                    in_if.start_x        <= pc.c[0];
                    in_if.start_y        <= pc.c[1];
                    in_if.start_z        <= pc.c[2];
                    in_if.start_handle_x <= pc.c[3];
                    in_if.start_handle_y <= pc.c[4];
                    in_if.start_handle_z <= pc.c[5];
                    in_if.end_x          <= pc.c[6];
                    in_if.end_y          <= pc.c[7];
                    in_if.end_z          <= pc.c[8];
                    in_if.end_handle_x   <= pc.c[9];
                    in_if.end_handle_y   <= pc.c[10];
                    in_if.end_handle_z   <= pc.c[11];
                    in_if.valid          <= 1'b1;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
            out_if.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (lengths.size() == 0) begin
                $error("unexpected piece_length transaction: actual %0d", out_if.piece_length);
                errors++;
            end else begin
                logic [47:0] want;
                want = lengths.pop_front();
                if (out_if.piece_length !== want) begin
                    $error("piece_length: expected %0d, actual %0d", want,
                           out_if.piece_length);
                    errors++;
                end
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
                || psel) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("watchdog expired with %0d lengths outstanding", lengths.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    initial begin
        int idle_set [4];
        int stall_set [4];
        idle_set  = '{0, 76, 0, 15};
        stall_set = '{0, 0, 76, 15};
        build_weights();
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        idle_pct = 0;
        stall_pct = 0;
        mode_bezier = 1'b1;
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.start_x = 0;
        in_if.start_y = 0;
        in_if.start_z = 0;
        in_if.start_handle_x = 0;
        in_if.start_handle_y = 0;
        in_if.start_handle_z = 0;
        in_if.end_x = 0;
        in_if.end_y = 0;
        in_if.end_z = 0;
        in_if.end_handle_x = 0;
        in_if.end_handle_y = 0;
        in_if.end_handle_z = 0;
        out_if.ready = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_directed();
        drain();
        reg_write(REG_BEZIER_MODE, 32'hFFFF_FFFE);
        add_directed();
        drain();
        // A write outside the register map must leave the mode alone.
        reg_write(PADDR_W'(4), 32'h1);
        add_random(4);
        drain();

        for (int ph = 0; ph < 8; ph++) begin
            reg_write(REG_BEZIER_MODE, (ph % 2 == 0) ? 32'h3 : 32'h0);
            idle_pct  = idle_set[ph / 2];
            stall_pct = stall_set[ph / 2];
            add_random(RATE_ITEMS / 8);
            drain();
        end

        $display("sent %0d pieces in both modes, checked %0d lengths", n_sent, n_checked);
        $display("covered extreme coordinates, sender gaps and output stalls");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire
